>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every rising edge outside reset
`define ASSERT_RST(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> hdl/ghal_pkg.sv
// ----------------------------------------------------------------------------
// ghal_pkg
// shared constants for the generational handle allocator
// ----------------------------------------------------------------------------
package ghal_pkg;

	// pool size, slot 0 is the sentinel
	localparam int SLOTS  = 1024;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// field widths
	localparam int IDX_W  = 16;
	localparam int GEN_W  = 16;
	localparam int FUNC_W = 3;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 16;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 32;

	// request codes
	localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_FREE    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_CHECK   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_RESOLVE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_NEXT    = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_BASE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITEM_SIZE = 4'd1;

	localparam logic [SIZE_W-1:0] ITEM_SIZE_RESET = 16'd4;

endpackage

>>> hdl/ghal_ram.sv
// ----------------------------------------------------------------------------
// ghal_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ghal_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/generational_handle_allocator_core.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_core
// slot map with generation-checked handles, free list and allocation list
// ----------------------------------------------------------------------------
// A request takes one input transfer and yields one result transfer. The
// slot sequencer steps through a registered read of the slot memories, the
// decision and the first write-back, a second link write for an alloc that
// finds a free slot or a free that acts (the prev and next link memories
// each take one write per cycle), a generation read of the successor for
// next, the index times item size multiply and the load of the result
// register, which waits for out_ready while it still holds a result; a new
// request is taken only after the result register is loaded. After reset
// the block sweeps all SLOTS entries of the three slot memories, one entry
// per cycle, before it takes its first request; configuration transfers
// are taken all the while. Head and tail of the allocated list are kept in
// flip-flops.
`include "assert_macros.svh"

module generational_handle_allocator_core
	import ghal_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [FUNC_W-1:0]     func,
	input  logic [IDX_W-1:0]      handle_index,
	input  logic [GEN_W-1:0]      handle_generation,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      result_index,
	output logic [GEN_W-1:0]      result_generation,
	output logic                  ok,
	output logic [ADDR_W-1:0]     item_address,
	// configuration channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EVAL,
		S_LINK,
		S_GEN,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;

	// sweep counter for the clearing pass
	logic [SLOT_W-1:0] init_cnt_q;

	// list heads
	logic [SLOT_W-1:0] free_head_q;
	logic [SLOT_W-1:0] head_q;   // first allocated slot, 0 when empty
	logic [SLOT_W-1:0] tail_q;   // last allocated slot, 0 when empty

	// configuration
	logic [ADDR_W-1:0] item_base_q;
	logic [SIZE_W-1:0] item_size_q;

	// latched request
	logic [FUNC_W-1:0] func_q;
	logic [IDX_W-1:0]  idx_q;
	logic [GEN_W-1:0]  hgen_q;

	// working result
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] res_idx_q;
	logic [GEN_W-1:0]  res_gen_q;
	logic              res_ok_q;
	logic              addr_en_q;
	logic [ADDR_W-1:0] prod_q;

	// result register
	logic              out_valid_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [GEN_W-1:0]  out_gen_q;
	logic              out_ok_q;
	logic [ADDR_W-1:0] out_addr_q;

	// memory ports
	logic              gen_we, prev_we, next_we;
	logic [SLOT_W-1:0] gen_waddr, prev_waddr, next_waddr;
	logic [GEN_W-1:0]  gen_wdata;
	logic [SLOT_W-1:0] prev_wdata, next_wdata;
	logic [SLOT_W-1:0] gen_raddr, link_raddr;
	logic [GEN_W-1:0]  gen_rd;
	logic [SLOT_W-1:0] prev_rd, next_rd;

	// decode helpers
	logic              port_in_range;
	logic [SLOT_W-1:0] port_slot;
	logic              in_range;
	logic [SLOT_W-1:0] idx_slot;
	logic              handle_ok;
	logic              listed;
	logic              free_act;
	logic              next_listed;
	logic [SLOT_W-1:0] next_succ;
	logic              init_last;
	logic [SLOT_W+SIZE_W-1:0] prod_full;

	assign port_in_range = 32'(handle_index) < SLOTS;
	assign port_slot     = port_in_range ? handle_index[SLOT_W-1:0] : '0;
	assign in_range      = 32'(idx_q) < SLOTS;
	assign idx_slot      = in_range ? idx_q[SLOT_W-1:0] : '0;

	// handle checks on the words read for the latched request
	assign handle_ok   = in_range && (gen_rd == hgen_q);
	assign listed      = in_range && (idx_q != '0) &&
	                     ((prev_rd != '0) || (head_q == idx_slot));
	assign free_act    = handle_ok && listed;
	assign next_listed = (idx_q == '0) || listed;
	assign next_succ   = (idx_q == '0) ? head_q : next_rd;

	assign init_last = (init_cnt_q == SLOT_W'(SLOTS - 1));

	assign prod_full = {{SIZE_W{1'b0}}, slot_q} * {{SLOT_W{1'b0}}, item_size_q};

	// read addresses: the free head for alloc or the slot named by a new request, or the successor for next
	always_comb begin
		if (state_q == S_IDLE) begin
			link_raddr = (func == FN_ALLOC) ? free_head_q : port_slot;
			gen_raddr  = link_raddr;
		end else begin
			link_raddr = idx_slot;
			gen_raddr  = next_succ;
		end
	end

	// write-back; reads of a request never share an edge with its writes
	always_comb begin
		gen_we     = 1'b0;
		prev_we    = 1'b0;
		next_we    = 1'b0;
		gen_waddr  = idx_slot;
		prev_waddr = idx_slot;
		next_waddr = idx_slot;
		gen_wdata  = gen_rd + GEN_W'(1);
		prev_wdata = '0;
		next_wdata = '0;
		unique case (state_q)
			S_INIT: begin
				// generation 0, prev 0, next i+1 inside the chain
				gen_we     = 1'b1;
				prev_we    = 1'b1;
				next_we    = 1'b1;
				gen_waddr  = init_cnt_q;
				prev_waddr = init_cnt_q;
				next_waddr = init_cnt_q;
				gen_wdata  = '0;
				prev_wdata = '0;
				next_wdata = ((init_cnt_q != '0) && !init_last) ?
				             init_cnt_q + SLOT_W'(1) : '0;
			end
			S_EVAL: begin
				if (func_q == FN_ALLOC && free_head_q != '0) begin
					// new tail: prev links to old tail, next ends the list
					prev_we    = 1'b1;
					next_we    = 1'b1;
					prev_waddr = free_head_q;
					next_waddr = free_head_q;
					prev_wdata = tail_q;
					next_wdata = '0;
				end else if (func_q == FN_FREE && free_act) begin
					// unlink from neighbors and bump generation
					gen_we     = 1'b1;
					prev_we    = 1'b1;
					next_we    = 1'b1;
					gen_waddr  = idx_slot;
					next_waddr = prev_rd;
					next_wdata = next_rd;
					prev_waddr = next_rd;
					prev_wdata = prev_rd;
				end
			end
			S_LINK: begin
				if (func_q == FN_ALLOC) begin
					next_we    = 1'b1;
					next_waddr = tail_q;
					next_wdata = slot_q;
				end else begin
					// push the freed slot on the free list
					prev_we    = 1'b1;
					next_we    = 1'b1;
					prev_waddr = idx_slot;
					prev_wdata = '0;
					next_waddr = idx_slot;
					next_wdata = free_head_q;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, list heads, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			init_cnt_q  <= '0;
			free_head_q <= SLOT_W'(1);
			head_q      <= '0;
			tail_q      <= '0;
			item_base_q <= '0;
			item_size_q <= ITEM_SIZE_RESET;
			func_q      <= '0;
			idx_q       <= '0;
			hgen_q      <= '0;
			slot_q      <= '0;
			res_idx_q   <= '0;
			res_gen_q   <= '0;
			res_ok_q    <= 1'b0;
			addr_en_q   <= 1'b0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_gen_q   <= '0;
			out_ok_q    <= 1'b0;
			out_addr_q  <= '0;
		end else begin
			// configuration transfers, writes past the list are dropped
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ITEM_BASE: item_base_q <= cfg_data;
					CFG_ITEM_SIZE: item_size_q <= cfg_data[SIZE_W-1:0];
					default: begin
					end
				endcase
			end

			// result transfer
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_INIT: begin
					init_cnt_q <= init_cnt_q + SLOT_W'(1);
					if (init_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						idx_q   <= handle_index;
						hgen_q  <= handle_generation;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					res_idx_q <= '0;
					res_gen_q <= '0;
					res_ok_q  <= 1'b0;
					addr_en_q <= 1'b0;
					slot_q    <= '0;
					state_q   <= S_MUL;
					unique case (func_q)
						FN_ALLOC: begin
							// empty pool still reports slot 0
							slot_q    <= free_head_q;
							res_idx_q <= free_head_q;
							res_gen_q <= gen_rd;
							res_ok_q  <= free_head_q != '0;
							addr_en_q <= 1'b1;
							if (free_head_q != '0) begin
								free_head_q <= next_rd;
								state_q     <= S_LINK;
							end
						end
						FN_FREE: begin
							res_ok_q <= free_act;
							if (free_act) begin
								if (prev_rd == '0) begin
									head_q <= next_rd;
								end
								if (next_rd == '0) begin
									tail_q <= prev_rd;
								end
								state_q <= S_LINK;
							end
						end
						FN_CHECK: begin
							res_ok_q <= handle_ok;
						end
						FN_RESOLVE: begin
							// invalid handle resolves to the sentinel
							res_ok_q  <= handle_ok;
							slot_q    <= handle_ok ? idx_slot : '0;
							addr_en_q <= 1'b1;
						end
						FN_NEXT: begin
							if (next_listed) begin
								slot_q    <= next_succ;
								res_idx_q <= next_succ;
								addr_en_q <= 1'b1;
								state_q   <= S_GEN;
							end
						end
						default: begin
						end
					endcase
				end
				S_LINK: begin
					if (func_q == FN_ALLOC) begin
						if (tail_q == '0) begin
							head_q <= slot_q;
						end
						tail_q <= slot_q;
					end else begin
						free_head_q <= idx_slot;
					end
					state_q <= S_MUL;
				end
				S_GEN: begin
					res_gen_q <= gen_rd;
					res_ok_q  <= slot_q != '0;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= ADDR_W'(prod_full);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// wait for room in the result register
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_idx_q   <= IDX_W'(res_idx_q);
						out_gen_q   <= res_gen_q;
						out_ok_q    <= res_ok_q;
						out_addr_q  <= addr_en_q ? item_base_q + prod_q : '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready          = (state_q == S_IDLE);
	assign cfg_ready         = 1'b1;
	assign out_valid         = out_valid_q;
	assign result_index      = out_idx_q;
	assign result_generation = out_gen_q;
	assign ok                = out_ok_q;
	assign item_address      = out_addr_q;

	ghal_ram #(
		.WIDTH(GEN_W),
		.DEPTH(SLOTS)
	) u_gen_ram (
		.clk  (clk),
		.we   (gen_we),
		.waddr(gen_waddr),
		.wdata(gen_wdata),
		.raddr(gen_raddr),
		.rdata(gen_rd)
	);

	ghal_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_prev_ram (
		.clk  (clk),
		.we   (prev_we),
		.waddr(prev_waddr),
		.wdata(prev_wdata),
		.raddr(link_raddr),
		.rdata(prev_rd)
	);

	ghal_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_next_ram (
		.clk  (clk),
		.we   (next_we),
		.waddr(next_waddr),
		.wdata(next_wdata),
		.raddr(link_raddr),
		.rdata(next_rd)
	);

	// no write-back while a new request may read the memories
	`ASSERT_RST(a_no_write_idle, clk, arst_n, (state_q == S_IDLE) |-> !(gen_we || prev_we || next_we))
	// allocated list is empty at both ends or at neither
	`ASSERT_RST(a_head_tail_empty, clk, arst_n, (head_q == '0) == (tail_q == '0))
	// free head and tail stay inside the pool
	`ASSERT_RST(a_heads_in_pool, clk, arst_n, (32'(free_head_q) < SLOTS) && (32'(tail_q) < SLOTS))
	// the free head moves only in the decision step of an alloc or the link step of a free
	`ASSERT_RST(a_free_head_moves, clk, arst_n, !$stable(free_head_q) |-> ($past(state_q) == S_EVAL || $past(state_q) == S_LINK))

endmodule
